FILE: rtl/ffa_pkg.sv
// Package for the first-fit arena allocator: operation kinds, status codes
// and the controller state type. No dependencies.
package ffa_pkg;

    // Operation kinds on the input channel.
    localparam logic [1:0] KIND_INIT    = 2'd0;
    localparam logic [1:0] KIND_ALLOC   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_DESTROY = 2'd3;

    // Status codes on the result channel.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNINIT = 2'd1;
    localparam logic [1:0] ST_BADARG = 2'd2;
    localparam logic [1:0] ST_NOMEM  = 2'd3;

    // Controller states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_INIT  = 13'b0000000000010,
        S_RD    = 13'b0000000000100,
        S_CK    = 13'b0000000001000,
        S_POP   = 13'b0000000010000,
        S_SPLIT = 13'b0000000100000,
        S_WCUR  = 13'b0000001000000,
        S_NXCK  = 13'b0000010000000,
        S_PVRD  = 13'b0000100000000,
        S_PVCK  = 13'b0001000000000,
        S_FIXGO = 13'b0010000000000,
        S_FIXCK = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } ffa_state_t;

endpackage

FILE: rtl/ffa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/first_fit_arena_allocator.sv
// Top level of the first-fit arena allocator; depends on ffa_pkg and ffa_ram.
// A rejected word or a destroy goes straight to the result hand-off; init writes one
// record first; allocate and release read the chain chunk by chunk and may add split or
// merge writes. One word at a time; a new word is taken while a result word waits.
// Synchronous active-low reset clears control state only; stack entries below
// a low-water mark are never written and their values are computed on a pop.
module first_fit_arena_allocator
    import ffa_pkg::*;
#(
    parameter int ARENA_MAX_BYTES = 16384,
    parameter int PAGE_BYTES      = 4096,
    parameter int HEADER_BYTES    = 32,
    parameter int MAX_CHUNKS      = 512
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_kind,
    input  logic [$clog2(ARENA_MAX_BYTES+1)-1:0] s_amount,
    input  logic [$clog2(ARENA_MAX_BYTES)-1:0] s_offset,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [$clog2(ARENA_MAX_BYTES)-1:0] m_data_offset,
    output logic [$clog2(ARENA_MAX_BYTES+1)-1:0] m_granted_bytes
);

    localparam int AW  = $clog2(ARENA_MAX_BYTES + 1);
    localparam int OW  = $clog2(ARENA_MAX_BYTES);
    localparam int SW  = $clog2(MAX_CHUNKS);
    localparam int LW  = SW + 1;
    localparam int RW  = 2 * AW + 1 + 2 * LW;
    localparam int RNW = $clog2(ARENA_MAX_BYTES + PAGE_BYTES);
    localparam logic [LW-1:0]  NIL   = LW'(MAX_CHUNKS);
    localparam logic [AW-1:0]  HDR   = AW'(HEADER_BYTES);
    localparam logic [AW:0]    HDRW  = (AW+1)'(HEADER_BYTES);
    localparam logic [RNW-1:0] PMASK = RNW'(PAGE_BYTES - 1);

    // Pack one chunk record.
    function automatic logic [RW-1:0] pack_rec(input logic [AW-1:0] st, input logic [AW-1:0] sz,
                                               input logic fr, input logic [LW-1:0] nx,
                                               input logic [LW-1:0] pv);
        pack_rec = {st, sz, fr, nx, pv};
    endfunction

    ffa_state_t state_reg, state_next;
    logic [1:0]    kind_reg, kind_next;
    logic [AW-1:0] amount_reg, amount_next;
    logic [OW-1:0] offset_reg, offset_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [AW-1:0] r_start_reg, r_start_next, r_size_reg, r_size_next;
    logic          r_free_reg, r_free_next;
    logic [LW-1:0] r_next_reg, r_next_next, r_prev_reg, r_prev_next;
    logic [LW-1:0] after_reg, after_next, owner_reg, owner_next;
    logic [SW-1:0] nw_reg, nw_next;
    logic          merged_reg, merged_next;
    logic [LW-1:0] count_reg, count_next, low_reg, low_next, first_reg, first_next;
    logic          ready_reg, ready_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [OW-1:0] res_data_reg, res_data_next;
    logic [AW-1:0] res_granted_reg, res_granted_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [OW-1:0] m_data_offset_reg, m_data_offset_next;
    logic [AW-1:0] m_granted_bytes_reg, m_granted_bytes_next;

    // Memory ports.
    logic          rec_we, rec_re;
    logic [SW-1:0] rec_waddr, rec_raddr;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic          stk_we, stk_re;
    logic [SW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    // Fields of the record read back.
    logic [AW-1:0] d_start, d_size;
    logic          d_free;
    logic [LW-1:0] d_next, d_prev;
    assign {d_start, d_size, d_free, d_next, d_prev} = rec_rdata;

    logic [LW-1:0]  pop_idx;
    logic [RNW-1:0] rounded;
    logic           fits, split_ok, match;

    assign pop_idx  = count_reg - LW'(1);
    assign rounded  = (RNW'(amount_reg) + PMASK) & ~PMASK;
    assign fits     = d_free && (d_size >= amount_reg);
    assign split_ok = ({1'b0, d_size} >= ({1'b0, amount_reg} + HDRW + (AW+1)'(1)))
                      && (count_reg != '0);
    assign match    = (({1'b0, d_start} + HDRW) == (AW+1)'(offset_reg));

    ffa_ram #(.WIDTH(RW), .DEPTH(MAX_CHUNKS)) u_rec_ram (
        .aclk(aclk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .re(rec_re), .raddr(rec_raddr), .rdata(rec_rdata)
    );

    ffa_ram #(.WIDTH(SW), .DEPTH(MAX_CHUNKS)) u_stk_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_data_offset   = m_data_offset_reg;
    assign m_granted_bytes = m_granted_bytes_reg;

    // Controller: chain walk, split and merge sequencing, result hand-off.
    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg;
        amount_next = amount_reg;
        offset_next = offset_reg;
        cur_next = cur_reg;
        r_start_next = r_start_reg;
        r_size_next = r_size_reg;
        r_free_next = r_free_reg;
        r_next_next = r_next_reg;
        r_prev_next = r_prev_reg;
        after_next = after_reg;
        owner_next = owner_reg;
        nw_next = nw_reg;
        merged_next = merged_reg;
        count_next = count_reg;
        low_next = low_reg;
        first_next = first_reg;
        ready_next = ready_reg;
        res_status_next = res_status_reg;
        res_data_next = res_data_reg;
        res_granted_next = res_granted_reg;
        m_valid_next = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_offset_next = m_data_offset_reg;
        m_granted_bytes_next = m_granted_bytes_reg;
        rec_we = 1'b0;
        rec_waddr = cur_reg[SW-1:0];
        rec_wdata = pack_rec(r_start_reg, r_size_reg, r_free_reg, r_next_reg, r_prev_reg);
        rec_re = 1'b0;
        rec_raddr = cur_reg[SW-1:0];
        stk_we = 1'b0;
        stk_waddr = count_reg[SW-1:0];
        stk_wdata = cur_reg[SW-1:0];
        stk_re = 1'b0;
        stk_raddr = pop_idx[SW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next = s_kind;
                    amount_next = s_amount;
                    offset_next = s_offset;
                    res_data_next = '0;
                    res_granted_next = '0;
                    res_status_next = ST_OK;
                    merged_next = 1'b0;
                    cur_next = first_reg;
                    state_next = S_DONE;
                    case (s_kind)
                        KIND_INIT: begin
                            if (s_amount == '0 || s_amount > AW'(ARENA_MAX_BYTES)) begin
                                res_status_next = ST_BADARG;
                            end else begin
                                state_next = S_INIT;
                            end
                        end
                        KIND_ALLOC: begin
                            if (!ready_reg) begin
                                res_status_next = ST_UNINIT;
                            end else if (s_amount == '0) begin
                                res_status_next = ST_BADARG;
                            end else if (first_reg >= NIL) begin
                                res_status_next = ST_NOMEM;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        KIND_RELEASE: begin
                            if (!ready_reg) begin
                                res_status_next = ST_UNINIT;
                            end else if (first_reg >= NIL) begin
                                res_status_next = ST_BADARG;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            if (ready_reg) begin
                                ready_next = 1'b0;
                                count_next = '0;
                                first_next = NIL;
                            end else begin
                                res_status_next = ST_UNINIT;
                            end
                        end
                    endcase
                end
            end

            // One free chunk covering the whole page-rounded arena.
            S_INIT: begin
                rec_we = 1'b1;
                rec_waddr = '0;
                rec_wdata = pack_rec('0, AW'(rounded - RNW'(HEADER_BYTES)), 1'b1, NIL, NIL);
                count_next = LW'(MAX_CHUNKS - 1);
                low_next = LW'(MAX_CHUNKS - 1);
                first_next = '0;
                ready_next = 1'b1;
                res_granted_next = AW'(rounded);
                state_next = S_DONE;
            end

            S_RD: begin
                rec_re = 1'b1;
                state_next = S_CK;
            end

            // Examine the chunk just read.
            S_CK: begin
                r_start_next = d_start;
                r_size_next = d_size;
                r_free_next = d_free;
                r_next_next = d_next;
                r_prev_next = d_prev;
                if (kind_reg == KIND_ALLOC) begin
                    if (fits) begin
                        res_data_next = OW'(d_start + HDR);
                        if (split_ok) begin
                            count_next = pop_idx;
                            if (pop_idx < low_reg) begin
                                nw_next = SW'(MAX_CHUNKS - 1) - pop_idx[SW-1:0];
                                low_next = pop_idx;
                                state_next = S_SPLIT;
                            end else begin
                                stk_re = 1'b1;
                                state_next = S_POP;
                            end
                        end else begin
                            rec_we = 1'b1;
                            rec_wdata = pack_rec(d_start, d_size, 1'b0, d_next, d_prev);
                            state_next = S_DONE;
                        end
                    end else if (d_next < NIL) begin
                        cur_next = d_next;
                        state_next = S_RD;
                    end else begin
                        res_status_next = ST_NOMEM;
                        state_next = S_DONE;
                    end
                end else begin
                    if (match) begin
                        if (d_free) begin
                            res_status_next = ST_BADARG;
                            state_next = S_DONE;
                        end else begin
                            r_free_next = 1'b1;
                            if (d_next < NIL) begin
                                rec_re = 1'b1;
                                rec_raddr = d_next[SW-1:0];
                                state_next = S_NXCK;
                            end else begin
                                state_next = S_PVRD;
                            end
                        end
                    end else if (d_next < NIL) begin
                        cur_next = d_next;
                        state_next = S_RD;
                    end else begin
                        res_status_next = ST_BADARG;
                        state_next = S_DONE;
                    end
                end
            end

            S_POP: begin
                nw_next = stk_rdata;
                state_next = S_SPLIT;
            end

            // Write the split-off remainder as a new free chunk.
            S_SPLIT: begin
                rec_we = 1'b1;
                rec_waddr = nw_reg;
                rec_wdata = pack_rec(r_start_reg + HDR + amount_reg,
                                     r_size_reg - amount_reg - HDR, 1'b1, r_next_reg, cur_reg);
                after_next = r_next_reg;
                r_next_next = LW'(nw_reg);
                r_size_next = amount_reg;
                r_free_next = 1'b0;
                state_next = S_WCUR;
            end

            S_WCUR: begin
                rec_we = 1'b1;
                owner_next = LW'(nw_reg);
                merged_next = 1'b1;
                state_next = S_FIXGO;
            end

            // Merge with the next chunk when it is free.
            S_NXCK: begin
                if (d_free) begin
                    r_size_next = r_size_reg + HDR + d_size;
                    r_next_next = d_next;
                    merged_next = 1'b1;
                    if (count_reg < NIL) begin
                        stk_we = 1'b1;
                        stk_wdata = r_next_reg[SW-1:0];
                        count_next = count_reg + LW'(1);
                    end
                end
                state_next = S_PVRD;
            end

            S_PVRD: begin
                after_next = r_next_reg;
                if (r_prev_reg < NIL) begin
                    rec_re = 1'b1;
                    rec_raddr = r_prev_reg[SW-1:0];
                    state_next = S_PVCK;
                end else begin
                    rec_we = 1'b1;
                    owner_next = cur_reg;
                    state_next = S_FIXGO;
                end
            end

            // Merge into the previous chunk when it is free.
            S_PVCK: begin
                rec_we = 1'b1;
                if (d_free) begin
                    rec_waddr = r_prev_reg[SW-1:0];
                    rec_wdata = pack_rec(d_start, d_size + HDR + r_size_reg, 1'b1,
                                         r_next_reg, d_prev);
                    owner_next = r_prev_reg;
                    merged_next = 1'b1;
                    if (count_reg < NIL) begin
                        stk_we = 1'b1;
                        count_next = count_reg + LW'(1);
                    end
                end else begin
                    owner_next = cur_reg;
                end
                state_next = S_FIXGO;
            end

            // Repoint the back link of the chunk after a changed span.
            S_FIXGO: begin
                if (merged_reg && after_reg < NIL) begin
                    rec_re = 1'b1;
                    rec_raddr = after_reg[SW-1:0];
                    state_next = S_FIXCK;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_FIXCK: begin
                rec_we = 1'b1;
                rec_waddr = after_reg[SW-1:0];
                rec_wdata = pack_rec(d_start, d_size, d_free, d_next, owner_reg);
                state_next = S_DONE;
            end

            // Hand the result word to the output register.
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_offset_next = (res_status_reg == ST_OK) ? res_data_reg : '0;
                    m_granted_bytes_next = res_granted_reg;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            low_reg <= '0;
            first_reg <= NIL;
            ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            merged_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            low_reg <= low_next;
            first_reg <= first_next;
            ready_reg <= ready_next;
            m_valid_reg <= m_valid_next;
            merged_reg <= merged_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        amount_reg <= amount_next;
        offset_reg <= offset_next;
        cur_reg <= cur_next;
        r_start_reg <= r_start_next;
        r_size_reg <= r_size_next;
        r_free_reg <= r_free_next;
        r_next_reg <= r_next_next;
        r_prev_reg <= r_prev_next;
        after_reg <= after_next;
        owner_reg <= owner_next;
        nw_reg <= nw_next;
        res_status_reg <= res_status_next;
        res_data_reg <= res_data_next;
        res_granted_reg <= res_granted_next;
        m_status_reg <= m_status_next;
        m_data_offset_reg <= m_data_offset_next;
        m_granted_bytes_reg <= m_granted_bytes_next;
    end

`ifndef ASSERT_OFF
    // The spare count never exceeds the slot count.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NIL)
        else $error("spare slot count out of range");

    // Untouched stack entries always lie below the stack top.
    a_low_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (ready_reg && state_reg == S_IDLE) |-> (low_reg <= count_reg))
        else $error("low-water mark above stack top");

    // A data offset is only reported with an ok status.
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data_offset != '0) |-> (m_status == ST_OK))
        else $error("data offset with failing status");

    // A granted size is only reported with an ok status.
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted_bytes != '0) |-> (m_status == ST_OK))
        else $error("granted size with failing status");
`endif

endmodule
